/* rtl/cftap_pkg.sv */
// Shared types, constants and CRC helper for the framed telemetry/ack parser.
`timescale 1ns / 1ps
`default_nettype none

package cftap_pkg;

  localparam int WIN_BYTES  = 16;
  localparam int FILL_W     = 5;
  localparam int TOTAL_W    = 32;
  localparam int ACK_BYTES  = 8;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] ACK_SOF  = 8'hA5;
  localparam logic [7:0] ACK_MARK = 8'h5B;
  localparam logic [7:0] TLM_HI   = 8'hAA;
  localparam logic [7:0] TLM_LO   = 8'h55;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_TLM  = 2'd1,
    EV_ACK  = 2'd2
  } event_t;

  // Index 15 holds the newest byte, index 0 the oldest of a full window.
  typedef logic [WIN_BYTES-1:0][7:0] window_t;

  typedef struct packed {
    logic ack_hit;
    logic ack_crc_err;
    logic tlm_hit;
    logic tlm_crc_err;
    logic drop;
  } match_t;

  // One byte of reflected CRC-16/MODBUS.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/crc16_framed_telemetry_ack_parser.sv */
// Top level of the sliding-window CRC-16 framed telemetry and ack parser.
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------------
//   input   | in_valid/in_stall  | rx_byte
//   output  | out_valid/out_stall| event_res, latched frame fields, four totals
//
// One byte is taken into the input register, then its whole frame check
// (window shift, two CRCs, marker compare) completes into the result
// registers once they are free: one transaction per cycle sustained while out_stall is low.
// The input register keeps filling while a result waits to be taken; both
// stall only when the result is held and the input register is occupied.
// Synchronous reset clears both valid flags, the window fill, latched fields and totals.
`timescale 1ns / 1ps
`default_nettype none

module crc16_framed_telemetry_ack_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       event_res,
  output logic [15:0]      telemetry_sequence,
  output logic [31:0]      angle_bits,
  output logic [31:0]      rate_bits,
  output logic [7:0]       ack_command,
  output logic [7:0]       ack_result,
  output logic [7:0]       ack_sequence,
  output logic [31:0]      telemetry_total,
  output logic [31:0]      ack_total,
  output logic [31:0]      crc_error_total,
  output logic [31:0]      discard_total
);

  // Input register
  logic                           s1_valid;
  logic [7:0]                     s1_byte;
  logic                           advance;
  logic                           step;

  // Window state: newest byte at the top, valid bytes are the top "fill".
  cftap_pkg::window_t             window;
  cftap_pkg::window_t             window_next;
  logic [cftap_pkg::FILL_W-1:0]   fill;
  logic [cftap_pkg::FILL_W-1:0]   fill_n;
  logic [cftap_pkg::FILL_W-1:0]   fill_next;
  cftap_pkg::match_t              hit;
  cftap_pkg::event_t              event_next;
  cftap_pkg::event_t              event_q;

  // Latched fields and totals double as the result register: they only
  // change when a new result is loaded.
  logic [cftap_pkg::TOTAL_W-1:0]  tlm_cnt;
  logic [cftap_pkg::TOTAL_W-1:0]  ack_cnt;
  logic [cftap_pkg::TOTAL_W-1:0]  err_cnt;
  logic [cftap_pkg::TOTAL_W-1:0]  dsc_cnt;
  logic [1:0]                     err_inc;

  // Advance the input register into the result register when it is free.
  assign advance  = !out_valid || !out_stall;
  assign step     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte <= rx_byte;
    end
  end

  // Shift the new byte in at the top; fill never holds a full window here.
  assign window_next = {s1_byte, window[cftap_pkg::WIN_BYTES-1:1]};
  assign fill_n      = fill + cftap_pkg::FILL_W'(1);

  cftap_match u_match (
    .win    (window_next),
    .fill_n (fill_n),
    .hit    (hit)
  );

  always_comb begin
    if (hit.ack_hit || hit.tlm_hit) begin
      fill_next = '0;
    end else if (hit.drop) begin
      // Drop the oldest byte: it falls below the valid region.
      fill_next = fill_n - cftap_pkg::FILL_W'(1);
    end else begin
      fill_next = fill_n;
    end

    if (hit.ack_hit) begin
      event_next = cftap_pkg::EV_ACK;
    end else if (hit.tlm_hit) begin
      event_next = cftap_pkg::EV_TLM;
    end else begin
      event_next = cftap_pkg::EV_NONE;
    end

    // A bad ack CRC and a bad telemetry CRC never land on one byte: byte 15 differs.
    err_inc = {1'b0, hit.ack_crc_err} + {1'b0, hit.tlm_crc_err};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      window  <= window_next;
      event_q <= event_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill               <= '0;
      telemetry_sequence <= '0;
      angle_bits         <= '0;
      rate_bits          <= '0;
      ack_command        <= '0;
      ack_result         <= '0;
      ack_sequence       <= '0;
      tlm_cnt            <= '0;
      ack_cnt            <= '0;
      err_cnt            <= '0;
      dsc_cnt            <= '0;
    end else if (step) begin
      fill    <= fill_next;
      err_cnt <= err_cnt + cftap_pkg::TOTAL_W'(err_inc);
      if (hit.drop) begin
        dsc_cnt <= dsc_cnt + cftap_pkg::TOTAL_W'(1);
      end
      if (hit.ack_hit) begin
        ack_command  <= window_next[10];
        ack_result   <= window_next[11];
        ack_sequence <= window_next[12];
        ack_cnt      <= ack_cnt + cftap_pkg::TOTAL_W'(1);
      end
      if (hit.tlm_hit) begin
        // Little-endian fields: sequence at 2, angle at 4, rate at 8.
        telemetry_sequence <= {window_next[3], window_next[2]};
        angle_bits         <= {window_next[7], window_next[6],
                               window_next[5], window_next[4]};
        rate_bits          <= {window_next[11], window_next[10],
                               window_next[9], window_next[8]};
        tlm_cnt            <= tlm_cnt + cftap_pkg::TOTAL_W'(1);
      end
    end
  end

  assign event_res       = event_q;
  assign telemetry_total = tlm_cnt[31:0];
  assign ack_total       = ack_cnt[31:0];
  assign crc_error_total = err_cnt[31:0];
  assign discard_total   = dsc_cnt[31:0];

endmodule

`default_nettype wire

/* rtl/cftap_match.sv */
// Frame detection on the shifted window: ack at the tail, telemetry on a full window.
`timescale 1ns / 1ps
`default_nettype none

module cftap_match (
  input  wire cftap_pkg::window_t            win,
  input  wire logic [cftap_pkg::FILL_W-1:0]  fill_n,
  output cftap_pkg::match_t                  hit
);

  logic        ack_mark;
  logic        ack_ok;
  logic        full;
  logic        tlm_mark;
  logic        tlm_ok;
  logic [15:0] ack_crc;
  logic [15:0] tlm_crc;

  // Ack frame occupies bytes 8..15: A5 5B cmd res seq crc_lo crc_hi 5B.
  always_comb begin
    ack_crc = cftap_pkg::CRC_INIT;
    for (int j = 10; j < 13; j++) begin
      ack_crc = cftap_pkg::crc16_byte(ack_crc, win[j]);
    end
  end

  // Telemetry frame occupies bytes 0..15; CRC over seq, angle and rate.
  always_comb begin
    tlm_crc = cftap_pkg::CRC_INIT;
    for (int j = 2; j < 12; j++) begin
      tlm_crc = cftap_pkg::crc16_byte(tlm_crc, win[j]);
    end
  end

  assign ack_mark = (fill_n >= cftap_pkg::FILL_W'(cftap_pkg::ACK_BYTES)) &&
                    (win[8] == cftap_pkg::ACK_SOF) && (win[9] == cftap_pkg::ACK_MARK) &&
                    (win[15] == cftap_pkg::ACK_MARK);
  assign ack_ok   = (ack_crc == {win[14], win[13]});
  assign full     = (fill_n == cftap_pkg::FILL_W'(cftap_pkg::WIN_BYTES));
  assign tlm_mark = full && !(ack_mark && ack_ok) &&
                    (win[0] == cftap_pkg::TLM_HI) && (win[1] == cftap_pkg::TLM_LO) &&
                    (win[14] == cftap_pkg::TLM_LO) && (win[15] == cftap_pkg::TLM_HI);
  assign tlm_ok   = (tlm_crc == {win[13], win[12]});

  always_comb begin
    hit.ack_hit     = ack_mark && ack_ok;
    hit.ack_crc_err = ack_mark && !ack_ok;
    hit.tlm_hit     = tlm_mark && tlm_ok;
    hit.tlm_crc_err = tlm_mark && !tlm_ok;
    hit.drop        = full && !(ack_mark && ack_ok) && !(tlm_mark && tlm_ok);
  end

endmodule

`default_nettype wire
